// File: rtl/modbus_rtu_crc_framer_macros.svh
// Assertion macros shared by the Modbus RTU CRC framer modules.
// Each macro expects the module to have i_clk and i_rst_n in scope.
`ifndef MODBUS_RTU_CRC_FRAMER_MACROS_SVH
`define MODBUS_RTU_CRC_FRAMER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MRCF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A trigger that must be followed in the next cycle by a consequence.
`define MRCF_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mrcf_pkg.sv
// Types and constants of the Modbus RTU CRC framer.
// Used by mrcf_frame, mrcf_rbuf and the top level; depends on nothing.
package mrcf_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic MODE_TX = 1'b0;
    localparam logic MODE_RX = 1'b1;

    // Results that one input item can cause at most (data byte and two CRC bytes).
    localparam int MAX_RESULTS = 3;

    // Default depth of the result queue; it must be at least MAX_RESULTS + 1.
    localparam int RBUF_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CRC    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        t_status    status;
        logic       end_of_frame;
    } t_out_item;

    // Results of one accepted item, packed from entry 0 upward.
    typedef struct packed {
        logic [1:0]                      cnt;
        t_out_item [MAX_RESULTS-1:0]     item;
    } t_push;

endpackage

// File: rtl/mrcf_frame.sv
// Frame state and per-item logic: CRC-16 update, receive hold-back and status.
// Depends on mrcf_pkg and the assertion macros header.
`include "modbus_rtu_crc_framer_macros.svh"

module mrcf_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  mrcf_pkg::t_in_item i_item,
    output mrcf_pkg::t_push    o_push
);
    import mrcf_pkg::*;

    logic [15:0]     r_crc;
    logic [15:0]     n_crc;
    logic [1:0][7:0] r_held;
    logic [1:0][7:0] n_held;
    logic [1:0]      r_held_cnt;
    logic [1:0]      n_held_cnt;
    logic [15:0]     w_crc_tx;
    logic [15:0]     w_crc_rx;
    t_status         w_status;
    t_push           w_push;

    // One byte through the reflected Modbus CRC, eight shift steps unrolled.
    function automatic logic [15:0] crc_take(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_out_item mk_result(input logic [7:0] b, input t_kind kind,
                                            input t_status st, input logic eof);
        t_out_item r;
        r.out_byte     = b;
        r.kind         = kind;
        r.status       = st;
        r.end_of_frame = eof;
        return r;
    endfunction

    assign w_crc_tx = crc_take(r_crc, i_item.data_byte);
    assign w_crc_rx = crc_take(r_crc, r_held[0]);

    always_comb begin
        n_crc      = r_crc;
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        w_push     = '0;
        w_status   = ST_OK;
        if (i_take) begin
            if (i_item.mode == MODE_TX) begin
                // Transmit discards any held receive bytes.
                n_held_cnt     = 2'd0;
                n_crc          = w_crc_tx;
                w_push.item[0] = mk_result(i_item.data_byte, KIND_DATA, ST_OK, 1'b0);
                w_push.cnt     = 2'd1;
                if (i_item.last_byte) begin
                    w_push.item[1] = mk_result(w_crc_tx[7:0], KIND_CRC, ST_OK, 1'b0);
                    w_push.item[2] = mk_result(w_crc_tx[15:8], KIND_CRC, ST_OK, 1'b1);
                    w_push.cnt     = 2'd3;
                end
            end else begin
                if (r_held_cnt == 2'd2) begin
                    // The older held byte is now known to be data.
                    n_crc          = w_crc_rx;
                    w_push.item[0] = mk_result(r_held[0], KIND_DATA, ST_OK, 1'b0);
                    w_push.cnt     = 2'd1;
                    n_held[0]      = r_held[1];
                    n_held[1]      = i_item.data_byte;
                end else begin
                    n_held[r_held_cnt[0]] = i_item.data_byte;
                    n_held_cnt            = r_held_cnt + 2'd1;
                end
                if (i_item.last_byte) begin
                    if (n_held_cnt != 2'd2) begin
                        w_status = ST_SHORT;
                    end else if ({n_held[1], n_held[0]} == n_crc) begin
                        w_status = ST_OK;
                    end else begin
                        w_status = ST_MISMATCH;
                    end
                    if (w_push.cnt == 2'd0) begin
                        w_push.item[0] = mk_result(8'h00, KIND_STATUS, w_status, 1'b1);
                    end else begin
                        w_push.item[1] = mk_result(8'h00, KIND_STATUS, w_status, 1'b1);
                    end
                    w_push.cnt = w_push.cnt + 2'd1;
                end
            end
            if (i_item.last_byte) begin
                n_crc      = CRC_INIT;
                n_held     = '0;
                n_held_cnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_held_cnt <= 2'd0;
        end else begin
            r_crc      <= n_crc;
            r_held_cnt <= n_held_cnt;
        end
        r_held <= n_held;
    end

    assign o_push = w_push;

    `MRCF_ASSERT(a_held_cnt_range, r_held_cnt != 2'd3, "held byte count out of range")
    `MRCF_ASSERT_NEXT(a_frame_reload, i_take && i_item.last_byte,
        r_crc == CRC_INIT && r_held_cnt == 2'd0, "frame state not reloaded after frame end")
    `MRCF_ASSERT(a_tx_result_cnt, !(i_take && i_item.mode == MODE_TX) ||
        w_push.cnt == 2'd1 || w_push.cnt == 2'd3, "transmit item gave wrong result count")

endmodule

// File: rtl/mrcf_rbuf.sv
// Result queue: takes up to three results per cycle, hands out one per cycle while not stalled.
// Depends on mrcf_pkg and the assertion macros header.
`include "modbus_rtu_crc_framer_macros.svh"

module mrcf_rbuf #(
    parameter int Depth = mrcf_pkg::RBUF_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrcf_pkg::t_push    i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_stall,
    output mrcf_pkg::t_out_item o_item
);
    import mrcf_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_out_item [Depth-1:0] r_mem;
    logic [PtrW-1:0]       r_wr;
    logic [PtrW-1:0]       r_rd;
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       n_count;
    logic                  w_pop;

    // Pointer plus a small offset, wrapped at the queue depth.
    function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] p, input logic [1:0] k);
        logic [PtrW+1:0] s;
        s = {2'b00, p} + (PtrW + 2)'(k);
        if (s >= (PtrW + 2)'(Depth)) begin
            s = s - (PtrW + 2)'(Depth);
        end
        return s[PtrW-1:0];
    endfunction

    assign w_pop   = (r_count != '0) && !i_stall;
    assign n_count = r_count + CntW'(i_push.cnt) - CntW'(w_pop);
    assign o_space = r_count <= CntW'(Depth - MAX_RESULTS);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= wrap_add(r_wr, i_push.cnt);
            r_rd    <= wrap_add(r_rd, {1'b0, w_pop});
            r_count <= n_count;
        end
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (2'(j) < i_push.cnt) begin
                r_mem[wrap_add(r_wr, 2'(j))] <= i_push.item[j];
            end
        end
    end

    `MRCF_ASSERT(a_count_bound, r_count <= CntW'(Depth), "result queue count above depth")
    `MRCF_ASSERT(a_no_overflow, (CntW + 1)'(r_count) + (CntW + 1)'(i_push.cnt) <=
        (CntW + 1)'(Depth), "results pushed without room")
    `MRCF_ASSERT_NEXT(a_count_track, 1'b1, r_count == $past(r_count) +
        CntW'($past(i_push.cnt)) - CntW'($past(w_pop)), "result queue count lost track")

endmodule

// File: rtl/modbus_rtu_crc_framer.sv
// Top level of the Modbus RTU CRC framer: frame logic feeding a result queue.
// Depends on mrcf_pkg, mrcf_frame and mrcf_rbuf.
//
// This block frames Modbus RTU traffic one byte per input item, using the
// Modbus CRC-16 (reflected polynomial 0xA001, start value 0xFFFF, no final
// inversion, sent low byte first). An item with mode 0 (transmit) is passed
// straight through as a data result; when it carries last_byte, two CRC
// results follow, low byte then high byte, the second marked end_of_frame.
// An item with mode 1 (receive) is held back: data results lag the input by
// two bytes, because the final two bytes of a frame are the received CRC and
// are never emitted. The receive frame ends with one status result (ok, CRC
// mismatch, or frame shorter than two bytes) marked end_of_frame; data is not
// zeroed on a mismatch, so the consumer must act on the status. Mode may change
// inside a frame: the CRC is shared, and a transmit byte drops any held
// receive bytes. Timing: the CRC update and the status compare are done in the
// cycle an item is accepted, and its results pass through the registered result
// queue to the output. The output delivers one result per cycle unless the
// consumer stalls, from a small queue with a single read port, which sets the
// rate: items that cause at most one result each are taken every cycle, while
// a transmit frame end (three results) can stall the input. The input stalls
// whenever the queue could not take the three results of a worst-case item,
// so i_in_valid/o_in_stall never wait on the consumer within the same cycle.
module modbus_rtu_crc_framer #(
    parameter int RbufDepth = mrcf_pkg::RBUF_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mrcf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mrcf_pkg::t_out_item o_out_item
);
    import mrcf_pkg::*;

    logic  w_space;
    logic  w_take;
    t_push w_push;

    // Stall depends only on the registered queue fill, never on the output stall.
    assign o_in_stall = !w_space;
    assign w_take     = i_in_valid && w_space;

    // Per-item logic: updates the CRC and hold-back state on each accepted
    // item and produces its results, packed from the first slot upward.
    mrcf_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_item),
        .o_push  (w_push)
    );

    // Result queue: registered entries feed the output directly, so the
    // output payload holds steady while the consumer stalls.
    mrcf_rbuf #(
        .Depth (RbufDepth)
    ) u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
